>>> rtl/tlvmac_pkg.sv
// shared types and constants for the tlv response mac extractor
package tlvmac_pkg;

	typedef struct packed {
		logic        command;
		logic [7:0]  data_byte;
		logic        end_of_datagram;
		logic [31:0] source_node;
		logic [31:0] source_port;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [47:0] mac_address;
		logic [15:0] error_code;
	} out_item_t;

	// input command codes
	localparam logic CMD_BYTE  = 1'b0;
	localparam logic CMD_START = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_ERR    = 2'd1;
	localparam logic [1:0] STATUS_WAIT   = 2'd2;
	localparam logic [1:0] STATUS_REJECT = 2'd3;

	// expected header bytes
	localparam logic [7:0] HDR_TYPE   = 8'h02;
	localparam logic [7:0] HDR_TXN_LO = 8'h01;
	localparam logic [7:0] HDR_TXN_HI = 8'h00;
	localparam logic [7:0] HDR_MSG_LO = 8'h5c;
	localparam logic [7:0] HDR_MSG_HI = 8'h00;
	localparam int         HDR_BYTES  = 7;

	// tlv codes
	localparam logic [7:0]  TLV_RESULT     = 8'h02;
	localparam logic [7:0]  TLV_MAC        = 8'h10;
	localparam logic [15:0] RESULT_LEN     = 16'd4;
	localparam logic [15:0] MAC_MIN_LEN    = 16'd7;
	localparam logic [7:0]  MAC_LEN_PREFIX = 8'h06;

endpackage

>>> rtl/tlvmac_parse.sv
// byte-serial header check, tlv walk and accumulators
module tlvmac_parse import tlvmac_pkg::*; #(
	parameter int MAX_DATAGRAM_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  in_item_t    item,
	input  logic [31:0] expected_node,
	input  logic [31:0] expected_port,
	output logic        res_valid,
	output out_item_t   res
);

	localparam int OFF_W = $clog2(MAX_DATAGRAM_BYTES + 1);
	localparam int CW    = 18;

	typedef enum logic [2:0] {
		PH_TYPE, PH_LEN_LO, PH_LEN_HI, PH_VALUE, PH_STOP
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE, KIND_RESULT, KIND_MAC
	} kind_t;

	logic [OFF_W-1:0] offset_q, offset_n;
	logic             header_ok_q, header_ok_n;
	logic [16:0]      payload_end_q, payload_end_n;
	logic [7:0]       type_q, type_n;
	logic [15:0]      length_q, length_n;
	phase_t           phase_q, phase_n;
	logic [15:0]      vidx_q, vidx_n;
	kind_t            kind_q, kind_n;
	logic [47:0]      scratch_q, scratch_n;
	logic             pres_valid_q, pres_valid_n;
	logic [15:0]      pres_q, pres_n;
	logic             pmac_valid_q, pmac_valid_n;
	logic [47:0]      pmac_q, pmac_n;
	logic             have_res_q, have_res_n;
	logic [15:0]      err_q, err_n;
	logic             have_mac_q, have_mac_n;
	logic [47:0]      mac_q, mac_n;

	logic             fin;
	logic [7:0]       b;
	logic [CW-1:0]    o_x, pe_x;
	logic [2:0]       lane;
	logic [1:0]       status;

	assign fin = have_res_q && (err_q != 16'd0 || have_mac_q);
	assign b   = item.data_byte;

	always_comb begin
		offset_n      = offset_q;
		header_ok_n   = header_ok_q;
		payload_end_n = payload_end_q;
		type_n        = type_q;
		length_n      = length_q;
		phase_n       = phase_q;
		vidx_n        = vidx_q;
		kind_n        = kind_q;
		scratch_n     = scratch_q;
		pres_valid_n  = pres_valid_q;
		pres_n        = pres_q;
		pmac_valid_n  = pmac_valid_q;
		pmac_n        = pmac_q;
		have_res_n    = have_res_q;
		err_n         = err_q;
		have_mac_n    = have_mac_q;
		mac_n         = mac_q;
		o_x           = CW'(offset_q);
		pe_x          = CW'(payload_end_q);
		lane          = 3'd0;
		status        = STATUS_WAIT;
		res_valid     = 1'b0;

		if (step) begin
			if (item.command == CMD_START) begin
				offset_n     = '0;
				header_ok_n  = 1'b1;
				payload_end_n = '0;
				type_n       = '0;
				length_n     = '0;
				phase_n      = PH_TYPE;
				vidx_n       = '0;
				kind_n       = KIND_NONE;
				scratch_n    = '0;
				pres_valid_n = 1'b0;
				pres_n       = '0;
				pmac_valid_n = 1'b0;
				pmac_n       = '0;
				have_res_n   = 1'b0;
				err_n        = '0;
				have_mac_n   = 1'b0;
				mac_n        = '0;
			end else begin
				if (!fin) begin
					if (item.source_node != expected_node
						|| item.source_port != expected_port)
						header_ok_n = 1'b0;
					if (offset_q < OFF_W'(MAX_DATAGRAM_BYTES)) begin
						offset_n = offset_q + OFF_W'(1);
						if (offset_q < OFF_W'(HDR_BYTES)) begin
							case (offset_q[2:0])
								3'd0: if (b != HDR_TYPE) header_ok_n = 1'b0;
								3'd1: if (b != HDR_TXN_LO) header_ok_n = 1'b0;
								3'd2: if (b != HDR_TXN_HI) header_ok_n = 1'b0;
								3'd3: if (b != HDR_MSG_LO) header_ok_n = 1'b0;
								3'd4: if (b != HDR_MSG_HI) header_ok_n = 1'b0;
								3'd5: payload_end_n = {9'd0, b};
								3'd6: payload_end_n = 17'(HDR_BYTES) + {1'b0, b, payload_end_q[7:0]};
								default: ;
							endcase
						end else begin
							case (phase_q)
								PH_TYPE: begin
									if (o_x + CW'(3) > pe_x) begin
										phase_n = PH_STOP;
									end else begin
										type_n  = b;
										phase_n = PH_LEN_LO;
									end
								end
								PH_LEN_LO: begin
									length_n = {8'h00, b};
									phase_n  = PH_LEN_HI;
								end
								PH_LEN_HI: begin
									length_n = {b, length_q[7:0]};
									if (o_x + CW'(1) + CW'(length_n) > pe_x) begin
										phase_n = PH_STOP;
									end else begin
										vidx_n    = '0;
										scratch_n = '0;
										if (type_q == TLV_RESULT && length_n == RESULT_LEN)
											kind_n = KIND_RESULT;
										else if (type_q == TLV_MAC && length_n >= MAC_MIN_LEN)
											kind_n = KIND_MAC;
										else
											kind_n = KIND_NONE;
										phase_n = (length_n == 16'd0) ? PH_TYPE : PH_VALUE;
									end
								end
								PH_VALUE: begin
									if (kind_q == KIND_RESULT && vidx_q < 16'd4) begin
										lane = {1'b0, vidx_q[1:0]};
										scratch_n[{lane, 3'b000} +: 8] = b;
									end else if (kind_q == KIND_MAC) begin
										if (vidx_q == 16'd0) begin
											if (b != MAC_LEN_PREFIX)
												kind_n = KIND_NONE;
										end else if (vidx_q <= 16'd6) begin
											lane = vidx_q[2:0] - 3'd1;
											scratch_n[{lane, 3'b000} +: 8] = b;
										end
									end
									vidx_n = vidx_q + 16'd1;
									if ({1'b0, vidx_q} + 17'd1 >= {1'b0, length_q}) begin
										if (kind_n == KIND_RESULT) begin
											pres_valid_n = 1'b1;
											pres_n = (scratch_n[15:0] == 16'd0) ? 16'd0
												: scratch_n[31:16];
										end else if (kind_n == KIND_MAC) begin
											pmac_valid_n = 1'b1;
											pmac_n       = scratch_n;
										end
										phase_n = PH_TYPE;
									end
								end
								default: ;
							endcase
						end
					end
				end

				if (item.end_of_datagram) begin
					res_valid = 1'b1;
					if (fin) begin
						status = (err_q != 16'd0) ? STATUS_ERR : STATUS_OK;
					end else if (!header_ok_n || offset_n < OFF_W'(HDR_BYTES)
						|| CW'(payload_end_n) > CW'(offset_n)) begin
						status = STATUS_REJECT;
					end else begin
						if (pres_valid_n) begin
							have_res_n = 1'b1;
							err_n      = pres_n;
						end
						if (pmac_valid_n) begin
							have_mac_n = 1'b1;
							mac_n      = pmac_n;
						end
						if (have_res_n && err_n != 16'd0)
							status = STATUS_ERR;
						else if (have_res_n && have_mac_n)
							status = STATUS_OK;
						else
							status = STATUS_WAIT;
					end
					// next datagram starts clean
					offset_n      = '0;
					header_ok_n   = 1'b1;
					payload_end_n = '0;
					type_n        = '0;
					length_n      = '0;
					phase_n       = PH_TYPE;
					vidx_n        = '0;
					kind_n        = KIND_NONE;
					scratch_n     = '0;
					pres_valid_n  = 1'b0;
					pres_n        = '0;
					pmac_valid_n  = 1'b0;
					pmac_n        = '0;
				end
			end
		end

		res.status      = status;
		res.mac_address = mac_n;
		res.error_code  = (status == STATUS_ERR) ? err_n : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q      <= '0;
			header_ok_q   <= 1'b1;
			payload_end_q <= '0;
			type_q        <= '0;
			length_q      <= '0;
			phase_q       <= PH_TYPE;
			vidx_q        <= '0;
			kind_q        <= KIND_NONE;
			scratch_q     <= '0;
			pres_valid_q  <= 1'b0;
			pres_q        <= '0;
			pmac_valid_q  <= 1'b0;
			pmac_q        <= '0;
			have_res_q    <= 1'b0;
			err_q         <= '0;
			have_mac_q    <= 1'b0;
			mac_q         <= '0;
		end else begin
			offset_q      <= offset_n;
			header_ok_q   <= header_ok_n;
			payload_end_q <= payload_end_n;
			type_q        <= type_n;
			length_q      <= length_n;
			phase_q       <= phase_n;
			vidx_q        <= vidx_n;
			kind_q        <= kind_n;
			scratch_q     <= scratch_n;
			pres_valid_q  <= pres_valid_n;
			pres_q        <= pres_n;
			pmac_valid_q  <= pmac_valid_n;
			pmac_q        <= pmac_n;
			have_res_q    <= have_res_n;
			err_q         <= err_n;
			have_mac_q    <= have_mac_n;
			mac_q         <= mac_n;
		end
	end

	// a finished request never falls back to unfinished without a start command
	a_fin_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fin && !(step && item.command == CMD_START) |=> fin)
		else $error("finished request lost its result");

	// a start command leaves the accumulators empty
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.command == CMD_START |=> !have_res_q && !have_mac_q && mac_q == 48'd0)
		else $error("accumulators not cleared by start");

	// the byte offset never runs past the cap
	a_offset_cap: assert property (@(posedge clk) disable iff (!arst_n)
		offset_q <= OFF_W'(MAX_DATAGRAM_BYTES))
		else $error("byte offset beyond the cap");

endmodule

>>> rtl/tlv_response_mac_extractor.sv
// Response parser that takes one datagram byte per cycle on the request channel, save while
// stalled, and, at each byte marked end_of_datagram, gives one result with status, stored mac
// and error word. A request is registered on acceptance and parsed from that register, where
// the header check, the tlv walk and the accumulator update all settle in one pass; the result
// is registered again before it is offered. The request side stalls only while a final byte
// waits behind an earlier result not yet taken. expected_node sits at address 0 and
// expected_port at address 4 and are written while idle by the user; the block does not enforce it.
module tlv_response_mac_extractor import tlvmac_pkg::*; #(
	parameter int MAX_DATAGRAM_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  in_item_t    req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output out_item_t   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic REG_NODE = 1'b0;
	localparam logic REG_PORT = 1'b1;

	logic [31:0] expected_node_q, expected_port_q;
	logic        valid_s1;
	in_item_t    item_s1;
	logic        rsp_valid_q;
	out_item_t   rsp_q;
	logic        yields, adv, res_valid;
	out_item_t   res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PORT) ? expected_port_q : expected_node_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_node_q <= '0;
			expected_port_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_NODE)
				expected_node_q <= pwdata;
			else
				expected_port_q <= pwdata;
		end
	end

	assign yields    = item_s1.command == CMD_BYTE && item_s1.end_of_datagram;
	assign adv       = valid_s1 && (!yields || !rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall)
			item_s1 <= req;
	end

	tlvmac_parse #(
		.MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES)
	) u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv),
		.item         (item_s1),
		.expected_node(expected_node_q),
		.expected_port(expected_port_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid)
			rsp_q <= res;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_stall |-> !res_valid)
		else $error("pending result overwritten");

	// error word is nonzero exactly when the status reports an error
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> ((rsp_q.status == STATUS_ERR) == (rsp_q.error_code != 16'd0)))
		else $error("error word does not match status");

	// stall only while a registered request is held
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && yields && rsp_valid_q)
		else $error("request side stalled without cause");

endmodule

>>> test/tlvmac_checker.sv
// checker for the tlv response mac extractor: watches the channels, predicts and compares
`timescale 1ns / 1ps
module tlvmac_checker import tlvmac_pkg::*; #(
	parameter int         MAX_BYTES = 256,
	parameter logic [2:0] NODE_ADDR = 3'd0,
	parameter logic [2:0] PORT_ADDR = 3'd4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  in_item_t    req,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  out_item_t   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          mismatches,
	output int          waiting,
	output int          n_ok,
	output int          n_err,
	output int          n_wait,
	output int          n_reject
);

	localparam int MAX_REPORTS = 10;

	typedef enum logic [2:0] {
		WALK_TYPE, WALK_LEN_LO, WALK_LEN_HI, WALK_VALUE, WALK_STOP
	} walk_t;
	typedef enum logic [1:0] {VAL_NONE, VAL_RESULT, VAL_MAC} val_kind_t;

	logic [31:0] cfg_node;
	logic [31:0] cfg_port;

	// per-datagram parse state
	int unsigned offset;
	int unsigned dg_end;
	int unsigned val_idx;
	bit          hdr_good;
	logic [7:0]  hold_type;
	logic [15:0] tlv_len;
	walk_t       walk;
	val_kind_t   val_kind;
	logic [47:0] val_acc;
	bit          pend_err_vld;
	logic [15:0] pend_err;
	bit          pend_mac_vld;
	logic [47:0] pend_mac;

	// per-request accumulators
	bit          got_result;
	logic [15:0] saved_err;
	bit          got_mac;
	logic [47:0] saved_mac;

	out_item_t   due_results [$];

	function automatic void clear_dgram();
		offset = 0;
		hdr_good = 1'b1;
		dg_end = 0;
		hold_type = '0;
		tlv_len = '0;
		walk = WALK_TYPE;
		val_idx = 0;
		val_kind = VAL_NONE;
		val_acc = '0;
		pend_err_vld = 1'b0;
		pend_err = '0;
		pend_mac_vld = 1'b0;
		pend_mac = '0;
	endfunction

	function automatic void clear_acc();
		got_result = 1'b0;
		saved_err = '0;
		got_mac = 1'b0;
		saved_mac = '0;
	endfunction

	function automatic bit request_done();
		return got_result && (saved_err != 0 || got_mac);
	endfunction

	function automatic void header_step(input int unsigned o, input logic [7:0] b);
		case (o)
			0: if (b != HDR_TYPE) hdr_good = 1'b0;
			1: if (b != HDR_TXN_LO) hdr_good = 1'b0;
			2: if (b != HDR_TXN_HI) hdr_good = 1'b0;
			3: if (b != HDR_MSG_LO) hdr_good = 1'b0;
			4: if (b != HDR_MSG_HI) hdr_good = 1'b0;
			5: dg_end = b;
			6: dg_end = HDR_BYTES + (dg_end | (int'(b) << 8));
			default: ;
		endcase
	endfunction

	function automatic void walk_step(input int unsigned o, input logic [7:0] b);
		case (walk)
			WALK_TYPE: begin
				if (o + 3 > dg_end) begin
					walk = WALK_STOP;
				end else begin
					hold_type = b;
					walk = WALK_LEN_LO;
				end
			end
			WALK_LEN_LO: begin
				tlv_len = {8'h00, b};
				walk = WALK_LEN_HI;
			end
			WALK_LEN_HI: begin
				tlv_len[15:8] = b;
				if (o + 1 + tlv_len > dg_end) begin
					walk = WALK_STOP;
				end else begin
					val_idx = 0;
					val_acc = '0;
					if (hold_type == TLV_RESULT && tlv_len == RESULT_LEN)
						val_kind = VAL_RESULT;
					else if (hold_type == TLV_MAC && tlv_len >= MAC_MIN_LEN)
						val_kind = VAL_MAC;
					else
						val_kind = VAL_NONE;
					walk = (tlv_len == 0) ? WALK_TYPE : WALK_VALUE;
				end
			end
			WALK_VALUE: begin
				if (val_kind == VAL_RESULT && val_idx < 4) begin
					val_acc[8*val_idx +: 8] = b;
				end else if (val_kind == VAL_MAC) begin
					if (val_idx == 0) begin
						if (b != MAC_LEN_PREFIX) val_kind = VAL_NONE;
					end else if (val_idx <= 6) begin
						val_acc[8*(val_idx-1) +: 8] = b;
					end
				end
				val_idx++;
				if (val_idx >= tlv_len) begin
					if (val_kind == VAL_RESULT) begin
						pend_err_vld = 1'b1;
						pend_err = (val_acc[15:0] == 0) ? 16'h0000 : val_acc[31:16];
					end else if (val_kind == VAL_MAC) begin
						pend_mac_vld = 1'b1;
						pend_mac = val_acc;
					end
					walk = WALK_TYPE;
				end
			end
			default: ;
		endcase
	endfunction

	// one accepted request; a final byte queues the status it must produce
	function automatic void parse_request(input in_item_t r);
		out_item_t  want;
		logic [1:0] st;
		if (r.command == CMD_START) begin
			clear_dgram();
			clear_acc();
			return;
		end
		if (!request_done()) begin
			if (r.source_node != cfg_node || r.source_port != cfg_port) hdr_good = 1'b0;
			if (offset < MAX_BYTES) begin
				if (offset < HDR_BYTES) header_step(offset, r.data_byte);
				else walk_step(offset, r.data_byte);
				offset++;
			end
		end
		if (!r.end_of_datagram) return;
		if (request_done()) begin
			st = (saved_err != 0) ? STATUS_ERR : STATUS_OK;
		end else if (!hdr_good || offset < HDR_BYTES || dg_end > offset) begin
			st = STATUS_REJECT;
		end else begin
			if (pend_err_vld) begin
				got_result = 1'b1;
				saved_err = pend_err;
			end
			if (pend_mac_vld) begin
				got_mac = 1'b1;
				saved_mac = pend_mac;
			end
			if (got_result && saved_err != 0) st = STATUS_ERR;
			else if (got_result && got_mac) st = STATUS_OK;
			else st = STATUS_WAIT;
		end
		clear_dgram();
		want.status = st;
		want.mac_address = saved_mac;
		want.error_code = (st == STATUS_ERR) ? saved_err : 16'h0000;
		due_results.push_back(want);
	endfunction

	function automatic void check_result(input out_item_t got);
		out_item_t want;
		case (got.status)
			STATUS_OK:     n_ok++;
			STATUS_ERR:    n_err++;
			STATUS_WAIT:   n_wait++;
			STATUS_REJECT: n_reject++;
			default: ;
		endcase
		if (due_results.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: unexpected result status %0d mac %012h err %04h",
					$realtime, got.status, got.mac_address, got.error_code);
			return;
		end
		want = due_results.pop_front();
		if (got.status !== want.status || got.mac_address !== want.mac_address ||
				got.error_code !== want.error_code) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display({"%0t: result mismatch, expected status %0d mac %012h err %04h,",
					" got status %0d mac %012h err %04h"},
					$realtime, want.status, want.mac_address, want.error_code,
					got.status, got.mac_address, got.error_code);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_node = '0;
			cfg_port = '0;
			clear_dgram();
			clear_acc();
			due_results.delete();
			mismatches = 0;
			waiting = 0;
			n_ok = 0;
			n_err = 0;
			n_wait = 0;
			n_reject = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == NODE_ADDR) cfg_node = pwdata;
				else if (paddr == PORT_ADDR) cfg_port = pwdata;
			end
			if (req_valid && !req_stall) parse_request(req);
			if (rsp_valid && !rsp_stall) check_result(rsp);
			waiting = due_results.size();
		end
	end

endmodule

>>> test/tb_tlv_response_mac_extractor.sv
// testbench top for the tlv response mac extractor: clock, reset, request traffic and verdict
`timescale 1ns / 1ps
module tb_tlv_response_mac_extractor import tlvmac_pkg::*;;

	localparam int         MAX_BYTES      = 256;
	localparam logic [2:0] NODE_ADDR      = 3'd0;
	localparam logic [2:0] PORT_ADDR      = 3'd4;
	localparam int         PHASE_ITEMS    = 270;
	localparam int         HOLD_CYCLES    = 300;
	localparam int         WATCHDOG_LIMIT = 5000;
	// a result goes through the request and result registers; settle time lets a trailing start drain
	localparam int         SETTLE_CYCLES  = 6;
	localparam int         DG_SLOTS       = 320;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	in_item_t    req;
	logic        rsp_valid;
	logic        rsp_stall;
	out_item_t   rsp;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int mismatches, waiting, n_ok, n_err, n_wait, n_reject;

	int          sent = 0;
	int          dg_total = 0;
	int          cfg_phases = 0;
	int          holds_done = 0;
	int          burst_left = 0;
	int          gap_max = 0;
	bit          hold_request = 1'b0;
	logic [31:0] cur_node;
	logic [31:0] cur_port;
	logic [7:0]  dg [0:DG_SLOTS-1];
	int          dg_len;
	int          quiet_cycles = 0;

	always #5 clk = ~clk;

	tlv_response_mac_extractor #(.MAX_DATAGRAM_BYTES(MAX_BYTES)) uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	tlvmac_checker #(
		.MAX_BYTES(MAX_BYTES), .NODE_ADDR(NODE_ADDR), .PORT_ADDR(PORT_ADDR)
	) chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.mismatches(mismatches), .waiting(waiting),
		.n_ok(n_ok), .n_err(n_err), .n_wait(n_wait), .n_reject(n_reject)
	);

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
				(psel && penable && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// receiver: stall density changes from stretch to stretch, long hold-off on demand
	initial begin
		int pct;
		int stretch;
		rsp_stall = 1'b0;
		forever begin
			case ($urandom_range(0, 3))
				0: pct = 0;
				1: pct = 25;
				2: pct = 60;
				default: pct = 90;
			endcase
			stretch = $urandom_range(20, 200);
			repeat (stretch) begin
				@(negedge clk);
				if (hold_request) begin
					rsp_stall = 1'b1;
					repeat (HOLD_CYCLES) @(negedge clk);
					hold_request = 1'b0;
					holds_done++;
				end
				rsp_stall = ($urandom_range(0, 99) < pct);
			end
		end
	end

	// all tasks below start and end right after a falling edge
	task automatic send_req(input in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				req_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		req = it;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		burst_left--;
		sent++;
	endtask

	task automatic send_start();
		in_item_t it;
		it.command = CMD_START;
		it.data_byte = 8'($urandom);
		it.end_of_datagram = 1'($urandom);
		it.source_node = $urandom;
		it.source_port = $urandom;
		send_req(it);
	endtask

	// hold requests back until every result has come out
	task automatic drain();
		req_valid = 1'b0;
		while (waiting != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic configure(input logic [31:0] node, input logic [31:0] port);
		drain();
		apb_write(NODE_ADDR, node);
		apb_write(PORT_ADDR, port);
		cur_node = node;
		cur_port = port;
		cfg_phases++;
	endtask

	function automatic void dg_put(input logic [7:0] b);
		dg[dg_len] = b;
		dg_len++;
	endfunction

	function automatic void dg_header();
		dg_len = 0;
		dg_put(HDR_TYPE);
		dg_put(HDR_TXN_LO);
		dg_put(HDR_TXN_HI);
		dg_put(HDR_MSG_LO);
		dg_put(HDR_MSG_HI);
		dg_put(8'h00);
		dg_put(8'h00);
	endfunction

	// declared payload length is the real one shifted by slack
	function automatic void dg_seal(input int slack);
		int msg;
		msg = dg_len - HDR_BYTES + slack;
		if (msg < 0) msg = 0;
		dg[5] = msg[7:0];
		dg[6] = msg[15:8];
	endfunction

	function automatic void dg_result(input logic [15:0] word, input logic [15:0] err);
		dg_put(TLV_RESULT);
		dg_put(RESULT_LEN[7:0]);
		dg_put(RESULT_LEN[15:8]);
		dg_put(word[7:0]);
		dg_put(word[15:8]);
		dg_put(err[7:0]);
		dg_put(err[15:8]);
	endfunction

	function automatic void dg_mac(input logic [15:0] len, input logic [7:0] prefix,
			input logic [47:0] mac);
		dg_put(TLV_MAC);
		dg_put(len[7:0]);
		dg_put(len[15:8]);
		dg_put(prefix);
		for (int i = 0; i < 6; i++) dg_put(mac[8*i +: 8]);
		for (int i = 7; i < len; i++) dg_put(8'($urandom));
	endfunction

	// fill shorter than len gives a tlv that runs past the payload
	function automatic void dg_raw(input logic [7:0] typ, input logic [15:0] len,
			input int fill);
		dg_put(typ);
		dg_put(len[7:0]);
		dg_put(len[15:8]);
		repeat (fill) dg_put(8'($urandom));
	endfunction

	function automatic void add_random_tlv();
		logic [15:0] word;
		logic [15:0] err;
		logic [15:0] len;
		logic [7:0]  prefix;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				word = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'($urandom);
				err = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
				dg_result(word, err);
			end
			3, 4, 5: begin
				len = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(8, 10)) : MAC_MIN_LEN;
				prefix = ($urandom_range(0, 7) == 0) ? 8'($urandom) : MAC_LEN_PREFIX;
				dg_mac(len, prefix, 48'({$urandom, $urandom}));
			end
			6: begin
				len = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3))
					: 16'($urandom_range(5, 6));
				dg_raw(TLV_RESULT, len, len);
			end
			7: begin
				len = 16'($urandom_range(0, 6));
				dg_raw(TLV_MAC, len, len);
			end
			default: begin
				len = 16'($urandom_range(0, 6));
				dg_raw(8'($urandom), len, len);
			end
		endcase
	endfunction

	// bad_at marks a byte from a foreign source, start_at a start request cutting in
	task automatic send_dgram(input int bad_at, input int start_at);
		in_item_t it;
		int       i;
		for (i = 0; i < dg_len; i++) begin
			if (i == start_at) send_start();
			it.command = CMD_BYTE;
			it.data_byte = dg[i];
			it.end_of_datagram = (i == dg_len - 1);
			it.source_node = cur_node;
			it.source_port = cur_port;
			if (i == bad_at) begin
				if ($urandom_range(0, 1) == 0)
					it.source_node = cur_node ^ (32'h1 << $urandom_range(0, 31));
				else
					it.source_port = cur_port ^ (32'h1 << $urandom_range(0, 31));
			end
			send_req(it);
		end
		dg_total++;
	endtask

	// near or beyond the cap; declared length either exact or set to end at the cap
	task automatic send_long_dgram();
		int fill;
		dg_header();
		fill = $urandom_range(230, 245);
		dg_raw(8'h7f, 16'(fill), fill);
		add_random_tlv();
		add_random_tlv();
		dg_seal(($urandom_range(0, 1) == 0) ? 0 : MAX_BYTES - dg_len);
		send_dgram(-1, -1);
	endtask

	task automatic random_dgram();
		int       kind;
		int       slack;
		int       bad_at;
		int       start_at;
		int       fill;
		int       ntlv;
		logic [7:0] typ;
		kind = $urandom_range(0, 99);
		if (kind >= 97) begin
			send_long_dgram();
			return;
		end
		slack = 0;
		bad_at = -1;
		start_at = -1;
		dg_header();
		ntlv = $urandom_range(0, 3);
		repeat (ntlv) add_random_tlv();
		if (kind >= 60 && kind < 68) begin
			slack = -int'($urandom_range(1, 4));
		end else if (kind >= 68 && kind < 74) begin
			slack = $urandom_range(1, 3);
		end else if (kind >= 91) begin
			fill = $urandom_range(0, 3);
			case ($urandom_range(0, 2))
				0: typ = TLV_RESULT;
				1: typ = TLV_MAC;
				default: typ = 8'($urandom);
			endcase
			dg_raw(typ, 16'(fill + $urandom_range(1, 20)), fill);
		end
		dg_seal(slack);
		if (kind >= 74 && kind < 80) begin
			dg[$urandom_range(0, 4)] ^= 8'(8'h01 << $urandom_range(0, 7));
		end else if (kind >= 80 && kind < 85) begin
			dg_len = $urandom_range(1, 6);
			if ($urandom_range(0, 1) == 0)
				for (int i = 0; i < dg_len; i++) dg[i] = 8'($urandom);
		end else if (kind >= 85 && kind < 91) begin
			bad_at = $urandom_range(0, dg_len - 1);
		end
		if ($urandom_range(0, 49) == 0) start_at = $urandom_range(0, dg_len - 1);
		send_dgram(bad_at, start_at);
	endtask

	task automatic random_phase(input int n_items);
		int stop_at;
		stop_at = sent + n_items;
		while (sent < stop_at) begin
			if ($urandom_range(0, 19) == 0) begin
				case ($urandom_range(0, 2))
					0: gap_max = 0;
					1: gap_max = 3;
					default: gap_max = 12;
				endcase
			end
			if ($urandom_range(0, 99) < 30) send_start();
			if ($urandom_range(0, 99) < 3) drain();
			random_dgram();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cur_node = '0;
		cur_port = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		configure(32'h0000_0000, 32'h0000_0000);

		// directed: short reject, success with nonzero result word but zero error,
		// then a repeat once the request is finished
		send_start();
		dg_len = 0;
		dg_put(8'hff);
		send_dgram(-1, -1);
		dg_header();
		dg_result(16'hffff, 16'h0000);
		dg_mac(MAC_MIN_LEN, MAC_LEN_PREFIX, 48'hffff_ffff_ffff);
		dg_seal(0);
		send_dgram(-1, -1);
		dg_len = 0;
		dg_put(8'h00);
		send_dgram(-1, -1);

		// receiver holds off while one-byte datagrams keep coming
		hold_request = 1'b1;
		repeat (40) begin
			dg_len = 0;
			dg_put(8'($urandom));
			send_dgram(-1, -1);
		end

		configure(32'hffff_ffff, 32'hffff_ffff);
		send_start();
		send_long_dgram();
		dg_header();
		dg_result(16'h0000, 16'h0000);
		dg_seal(0);
		send_dgram(3, -1);
		random_phase(PHASE_ITEMS);

		configure($urandom, $urandom);
		gap_max = 3;
		random_phase(PHASE_ITEMS);

		configure($urandom, $urandom);
		gap_max = 12;
		random_phase(PHASE_ITEMS);

		req_valid = 1'b0;
		while (waiting != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("covered %0d requests in %0d datagrams over %0d address settings, %0d hold-offs",
			sent, dg_total, cfg_phases, holds_done);
		$display("results seen: %0d success, %0d error, %0d waiting, %0d rejected; %0d mismatches",
			n_ok, n_err, n_wait, n_reject, mismatches);
		if (mismatches == 0 && waiting == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
